[hdl/hrlp_pkg.sv]
`timescale 1ns / 1ps

package hrlp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       verb;
      logic [7:0] out_byte;
   } rsp_type;

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_MATCH   = 6'b000010,
      PH_PATH    = 6'b000100,
      PH_QUERY   = 6'b001000,
      PH_VERSION = 6'b010000,
      PH_DONE    = 6'b100000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] match_pos;
      logic       verb_seen;
   } parse_state_type;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_PATH    = 3'd1;
   localparam logic [2:0] KIND_VERSION = 3'd2;
   localparam logic [2:0] KIND_OK      = 3'd3;
   localparam logic [2:0] KIND_BAD     = 3'd4;

   localparam logic VERB_GET  = 1'b0;
   localparam logic VERB_POST = 1'b1;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_G     = 8'h47;
   localparam logic [7:0] CHAR_P     = 8'h50;

   localparam logic [2:0] GET_LEN  = 3'd4;
   localparam logic [2:0] POST_LEN = 3'd5;

   function automatic logic [7:0] prefix_char(input logic verb, input logic [2:0] pos);
      logic [7:0] c;
      c = CHAR_SPACE;
      if (verb == VERB_POST) begin
         case (pos)
            3'd0:    c = 8'h50;
            3'd1:    c = 8'h4F;
            3'd2:    c = 8'h53;
            3'd3:    c = 8'h54;
            default: c = CHAR_SPACE;
         endcase
      end else begin
         case (pos)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h54;
            default: c = CHAR_SPACE;
         endcase
      end
      return c;
   endfunction

endpackage

[hdl/hrlp_step.sv]
`timescale 1ns / 1ps

module hrlp_step
   import hrlp_pkg::*;
(
   input  req_type         item,
   input  parse_state_type state_cur,
   output parse_state_type state_nxt,
   output rsp_type         result
);

   phase_type  ph;
   logic [2:0] pos;
   logic       vb;
   logic       ends;
   logic [2:0] len;
   logic [2:0] pos_inc;
   logic [7:0] b;

   always_comb begin
      b    = item.data_byte;
      ends = item.end_of_text || (b == CHAR_NUL);
      ph   = item.first_byte ? PH_MATCH : state_cur.phase;
      pos  = item.first_byte ? 3'd0 : state_cur.match_pos;
      vb   = item.first_byte ? VERB_GET : state_cur.verb_seen;

      // verb picked up on the first prefix character
      if (ph == PH_MATCH && !ends && pos == 3'd0) begin
         if (b == CHAR_G) begin
            vb = VERB_GET;
         end else if (b == CHAR_P) begin
            vb = VERB_POST;
         end
      end

      len     = (vb == VERB_POST) ? POST_LEN : GET_LEN;
      pos_inc = pos + 3'd1;

      state_nxt.phase     = ph;
      state_nxt.match_pos = pos;
      state_nxt.verb_seen = vb;
      result.kind         = KIND_NONE;
      result.verb         = vb;
      result.out_byte     = 8'd0;

      case (ph)
         PH_MATCH: begin
            if (ends) begin
               state_nxt.phase = PH_DONE;
               result.kind     = KIND_BAD;
            end else if (pos == 3'd0 && b != CHAR_G && b != CHAR_P) begin
               state_nxt.phase = PH_DONE;
               result.kind     = KIND_BAD;
            end else if (pos >= len) begin
               state_nxt.phase = PH_PATH;
            end else if (b != prefix_char(vb, pos)) begin
               state_nxt.phase = PH_DONE;
               result.kind     = KIND_BAD;
            end else begin
               state_nxt.match_pos = pos_inc;
               if (pos_inc == len) begin
                  state_nxt.phase = PH_PATH;
               end
            end
         end
         PH_PATH, PH_QUERY: begin
            if (ends) begin
               state_nxt.phase = PH_DONE;
               result.kind     = KIND_OK;
            end else if (b == CHAR_SPACE) begin
               state_nxt.phase = PH_VERSION;
            end else if (ph == PH_PATH && b != CHAR_QMARK) begin
               result.kind     = KIND_PATH;
               result.out_byte = b;
            end else begin
               state_nxt.phase = PH_QUERY;
            end
         end
         PH_VERSION: begin
            if (ends || b == CHAR_CR || b == CHAR_LF) begin
               state_nxt.phase = PH_DONE;
               result.kind     = KIND_OK;
            end else begin
               result.kind     = KIND_VERSION;
               result.out_byte = b;
            end
         end
         PH_IDLE: begin
            state_nxt.phase = PH_IDLE;
         end
         default: begin
            state_nxt.phase = PH_DONE;
         end
      endcase
   end

endmodule

[hdl/http_request_line_parser_core.sv]
`timescale 1ns / 1ps

// HTTP request line parser: one byte beat in, one result beat out per byte.
// Each byte is captured in an input register, then a single pass of phase
// logic writes its tag into the result register and the next parser state
// into the state register, so a byte is taken every cycle when nothing
// stalls. The result register frees the input side as soon as its beat is
// taken; rsp_stall holds both stages.

module http_request_line_parser_core
   import hrlp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic            in_valid_ff;
   logic            in_valid_in;
   req_type         in_item_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_type         out_item_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type step_state;
   rsp_type         step_result;
   logic            out_free;
   logic            advance;

   hrlp_step u_step (
      .item      (in_item_ff),
      .state_cur (state_ff),
      .state_nxt (step_state),
      .result    (step_result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);
   assign state_in     = advance ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         state_ff.phase     <= PH_IDLE;
         state_ff.match_pos <= 3'd0;
         state_ff.verb_seen <= VERB_GET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
   import hrlp_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int END_WAIT = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   http_request_line_parser_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   req_type byte_queue[$];
   rsp_type expected_tags[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit sender_hold = 1'b0;
   int stim_count = 0;
   int mismatches = 0;
   int beats_checked = 0;
   int path_beats = 0;
   int version_beats = 0;
   int lines_ok = 0;
   int lines_bad = 0;
   int idle_cycles = 0;

   // parser state mirror
   phase_type  ph = PH_IDLE;
   logic [2:0] pos = 3'd0;
   logic       verb_r = VERB_GET;
   string      get_word = "GET ";
   string      post_word = "POST ";

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic rsp_type parse_byte(input req_type r);
      rsp_type    res;
      logic       ends;
      logic [7:0] b;
      logic [7:0] want;
      logic [2:0] len;
      b = r.data_byte;
      ends = r.end_of_text || b == CHAR_NUL;
      res.kind = KIND_NONE;
      res.out_byte = 8'h00;
      if (r.first_byte) begin
         ph = PH_MATCH;
         pos = 3'd0;
         verb_r = VERB_GET;
      end
      case (ph)
         PH_MATCH: begin
            if (ends) begin
               ph = PH_DONE;
               res.kind = KIND_BAD;
            end else begin
               if (pos == 3'd0 && b == CHAR_P) verb_r = VERB_POST;
               else if (pos == 3'd0 && b == CHAR_G) verb_r = VERB_GET;
               len = (verb_r == VERB_POST) ? POST_LEN : GET_LEN;
               want = (verb_r == VERB_POST) ? post_word[pos] : get_word[pos];
               if (b != want) begin
                  ph = PH_DONE;
                  res.kind = KIND_BAD;
               end else begin
                  pos = pos + 3'd1;
                  if (pos == len) ph = PH_PATH;
               end
            end
         end
         PH_PATH, PH_QUERY: begin
            if (ends) begin
               ph = PH_DONE;
               res.kind = KIND_OK;
            end else if (b == CHAR_SPACE) begin
               ph = PH_VERSION;
            end else if (ph == PH_PATH && b != CHAR_QMARK) begin
               res.kind = KIND_PATH;
               res.out_byte = b;
            end else begin
               ph = PH_QUERY;
            end
         end
         PH_VERSION: begin
            if (ends || b == CHAR_CR || b == CHAR_LF) begin
               ph = PH_DONE;
               res.kind = KIND_OK;
            end else begin
               res.kind = KIND_VERSION;
               res.out_byte = b;
            end
         end
         default: begin
         end
      endcase
      res.verb = verb_r;
      return res;
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (!sender_hold && byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= byte_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, prediction and checking
   always @(posedge clock) begin
      rsp_type want;
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!reset && req_valid && !req_stall) expected_tags.push_back(parse_byte(req_payload));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tags.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result beat kind %0d verb %0d byte %0h", $time,
                     rsp_payload.kind, rsp_payload.verb, rsp_payload.out_byte);
         end else begin
            want = expected_tags.pop_front();
            beats_checked++;
            compare_field("kind", 8'(want.kind), 8'(rsp_payload.kind));
            compare_field("verb", 8'(want.verb), 8'(rsp_payload.verb));
            compare_field("out_byte", want.out_byte, rsp_payload.out_byte);
            case (want.kind)
               KIND_PATH:    path_beats++;
               KIND_VERSION: version_beats++;
               KIND_OK:      lines_ok++;
               KIND_BAD:     lines_bad++;
               default: begin
               end
            endcase
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic first, input logic eot);
      req_type r;
      r.data_byte = b;
      r.first_byte = first;
      r.end_of_text = eot;
      byte_queue.push_back(r);
      stim_count++;
   endtask

   task automatic queue_text(input string text);
      for (int i = 0; i < text.len(); i++) queue_byte(text[i], i == 0, 1'b0);
   endtask

   function automatic logic [7:0] path_char();
      case ($urandom_range(15))
         0:       return CHAR_QMARK;
         1:       return 8'($urandom_range(1, 255));
         2:       return $urandom_range(1) ? CHAR_CR : CHAR_LF;
         default: return 8'($urandom_range(8'h21, 8'h7e));
      endcase
   endfunction

   task automatic queue_request();
      string   word;
      int      cut;
      int      n;
      word = $urandom_range(1) ? post_word : get_word;
      cut = ($urandom_range(7) == 0) ? $urandom_range(word.len() - 1) : -1;
      for (int i = 0; i < word.len(); i++) begin
         if (i == cut) queue_byte(8'($urandom_range(255)), i == 0, $urandom_range(3) == 0);
         else queue_byte(word[i], i == 0, 1'b0);
      end
      n = $urandom_range(10);
      for (int i = 0; i < n; i++) queue_byte(path_char(), 1'b0, 1'b0);
      if ($urandom_range(7) == 0) begin
         queue_byte(8'($urandom_range(255)), 1'b0, 1'b1);
      end else begin
         queue_byte(CHAR_SPACE, 1'b0, 1'b0);
         n = $urandom_range(8);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) queue_byte(8'($urandom_range(1, 255)), 1'b0, 1'b0);
            else queue_byte(8'($urandom_range(8'h21, 8'h7e)), 1'b0, 1'b0);
         end
         case ($urandom_range(9))
            0, 1, 2: queue_byte(CHAR_CR, 1'b0, 1'b0);
            3, 4, 5: queue_byte(CHAR_LF, 1'b0, 1'b0);
            6:       queue_byte(CHAR_NUL, 1'b0, 1'b0);
            7, 8:    queue_byte(8'($urandom_range(255)), 1'b0, 1'b1);
            default: begin
               // line cut short, next request restarts it
            end
         endcase
      end
      // trailing bytes after a completed or rejected line are ignored by the block
      n = $urandom_range(2);
      for (int i = 0; i < n; i++)
         queue_byte(8'($urandom_range(255)), 1'b0, $urandom_range(1) == 1);
   endtask

   task automatic queue_random(input int count);
      int target;
      int n;
      target = stim_count + count;
      while (stim_count < target) begin
         if ($urandom_range(99) < 85) begin
            queue_request();
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               queue_byte(8'($urandom_range(255)), $urandom_range(7) == 0,
                          $urandom_range(15) == 0);
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (req_valid || expected_tags.size() != 0 ||
             (!sender_hold && byte_queue.size() != 0))
         @(negedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      recv_stall_pct = 85;
      queue_byte(8'hFF, 1'b0, 1'b0);
      queue_text("GET a?z 1\n");
      queue_byte("x", 1'b0, 1'b0);
      queue_text("POST \r\n");
      queue_byte(8'hFF, 1'b0, 1'b1);
      queue_byte(CHAR_NUL, 1'b1, 1'b1);
      queue_text("GX");
      queue_text("P");
      queue_byte(CHAR_NUL, 1'b0, 1'b0);
      queue_random(200);
      wait_drained();

      send_idle_pct = 85;
      recv_stall_pct = 16;
      queue_random(215);
      @(negedge clock);
      while (byte_queue.size() > 100) @(negedge clock);
      // sender holds off until every pending result is out
      sender_hold = 1'b1;
      wait_drained();
      sender_hold = 1'b0;
      wait_drained();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      queue_random(215);
      wait_drained();

      repeat (END_WAIT) @(posedge clock);
      $display("%0d request bytes sent, %0d result beats checked", stim_count, beats_checked);
      $display("%0d lines completed, %0d rejected, %0d path and %0d version bytes passed",
               lines_ok, lines_bad, path_beats, version_beats);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[files.f]
hdl/hrlp_pkg.sv
hdl/hrlp_step.sv
hdl/http_request_line_parser_core.sv
verif/tb.sv
